>>> src/kott_pkg.sv
// Package for the keyed one-shot timer table.
// Holds the command and status codes, the default sizes and the cell control word.
// Depends on nothing.
package kott_pkg;

  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_KEY_BITS    = 16;

  localparam int OUT_KEY_W   = 16;
  localparam int OUT_CNT_W   = 5;
  localparam int TIME_W      = 32;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_CANCEL = 2'd2,
    MODE_CHECK  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    STAT_ADDED    = 3'd0,
    STAT_REARMED  = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_REMOVED  = 3'd3,
    STAT_NOTFOUND = 3'd4,
    STAT_CLEARED  = 3'd5,
    STAT_EXPIRY   = 3'd6
  } status_t;

  typedef struct packed {
    logic shift;
    logic wr_en;
  } kott_ctl_t;

endpackage

>>> src/kott_cell.sv
// One entry of the timer table: key, timeout and start time.
// Loads from its upper neighbor on a shift, or from the write bus when selected.
// Depends on kott_pkg.
module kott_cell
  import kott_pkg::*;
#(
  parameter int KEY_BITS = DEF_KEY_BITS,
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic                clk,
  input  kott_ctl_t           ctl,
  input  logic [IDX_W-1:0]    wr_idx,
  input  logic [KEY_BITS-1:0] wr_key,
  input  logic [TIME_W-1:0]   wr_timeout,
  input  logic [TIME_W-1:0]   wr_start,
  input  logic [KEY_BITS-1:0] nbr_key,
  input  logic [TIME_W-1:0]   nbr_timeout,
  input  logic [TIME_W-1:0]   nbr_start,
  output logic [KEY_BITS-1:0] key,
  output logic [TIME_W-1:0]   timeout,
  output logic [TIME_W-1:0]   start_time
);

  logic [KEY_BITS-1:0] key_r;
  logic [TIME_W-1:0]   timeout_r;
  logic [TIME_W-1:0]   start_r;
  logic                wr_here;

  assign wr_here = ctl.wr_en && (wr_idx == IDX_W'(CELL_IDX));

  always_ff @(posedge clk) begin
    if (wr_here) begin
      key_r     <= wr_key;
      timeout_r <= wr_timeout;
      start_r   <= wr_start;
    end else if (ctl.shift) begin
      key_r     <= nbr_key;
      timeout_r <= nbr_timeout;
      start_r   <= nbr_start;
    end
  end

  assign key        = key_r;
  assign timeout    = timeout_r;
  assign start_time = start_r;

endmodule

>>> src/kott_ctrl.sv
// Sequencer of the timer table: takes a command word, for add, remove and check rotates the
// table through the head cell once, decides keep, re-arm or drop per entry and issues results.
// Depends on kott_pkg.
module kott_ctrl
  import kott_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = DEF_KEY_BITS,
  parameter int CNT_W       = $clog2(TABLE_DEPTH + 1),
  parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_mode,
  input  logic [15:0]          in_key,
  input  logic [TIME_W-1:0]    in_timeout_ms,
  input  logic [TIME_W-1:0]    in_now_ms,
  input  logic [KEY_BITS-1:0]  head_key,
  input  logic [TIME_W-1:0]    head_timeout,
  input  logic [TIME_W-1:0]    head_start,
  output kott_ctl_t            ctl,
  output logic [IDX_W-1:0]     wr_idx,
  output logic [KEY_BITS-1:0]  wr_key,
  output logic [TIME_W-1:0]    wr_timeout,
  output logic [TIME_W-1:0]    wr_start,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic                 out_expired_valid,
  output logic [OUT_KEY_W-1:0] out_expired_key,
  output logic                 out_last,
  output logic [OUT_CNT_W-1:0] out_entries_in_use
);

  localparam int CW = (KEY_BITS < OUT_KEY_W) ? KEY_BITS : OUT_KEY_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  logic                 busy_r, busy_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic                 found_r, found_nxt;
  mode_t                mode_r, mode_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic [TIME_W-1:0]    timeout_r, timeout_nxt;
  logic [TIME_W-1:0]    now_r, now_nxt;

  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic                 out_exp_r, out_exp_nxt;
  logic [OUT_KEY_W-1:0] out_key_r, out_key_nxt;
  logic                 out_last_r, out_last_nxt;
  logic [OUT_CNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic [KEY_BITS-1:0]  key_in;
  logic [CNT_W-1:0]     cnt_m1;
  logic [TIME_W-1:0]    elapsed;
  logic                 expired;
  logic                 match;
  logic                 drop;

  assign key_in  = KEY_BITS'(in_key[CW-1:0]);
  assign cnt_m1  = count_r - 1'b1;
  assign elapsed = now_r - head_start;
  assign expired = elapsed >= head_timeout;
  assign match   = head_key == key_r;
  assign drop    = ((mode_r == MODE_CHECK) && expired) || ((mode_r == MODE_REMOVE) && match);

  always_comb begin
    state_nxt      = state_r;
    busy_nxt       = busy_r;
    count_nxt      = count_r;
    rem_nxt        = rem_r;
    found_nxt      = found_r;
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    timeout_nxt    = timeout_r;
    now_nxt        = now_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_exp_nxt    = 1'b0;
    out_key_nxt    = '0;
    out_last_nxt   = 1'b1;
    out_cnt_nxt    = out_cnt_r;
    ctl            = '0;
    wr_idx         = IDX_W'(cnt_m1);
    wr_key         = head_key;
    wr_timeout     = head_timeout;
    wr_start       = head_start;

    case (state_r)
      S_IDLE: begin
        if (start && !busy_r) begin
          mode_nxt    = mode_t'(in_mode);
          key_nxt     = key_in;
          timeout_nxt = in_timeout_ms;
          now_nxt     = in_now_ms;
          rem_nxt     = count_r;
          found_nxt   = 1'b0;
          if (mode_t'(in_mode) == MODE_CANCEL) begin
            count_nxt      = '0;
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_CLEARED;
            out_cnt_nxt    = '0;
          end else if ((mode_t'(in_mode) == MODE_ADD) &&
                       (count_r >= CNT_W'(TABLE_DEPTH))) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_FULL;
            out_cnt_nxt    = OUT_CNT_W'(count_r);
          end else begin
            state_nxt = S_SCAN;
            busy_nxt  = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (rem_r != '0) begin
          rem_nxt   = rem_r - 1'b1;
          ctl.shift = 1'b1;
          ctl.wr_en = !drop;
          if (match) begin
            found_nxt = 1'b1;
          end
          if ((mode_r == MODE_ADD) && match) begin
            wr_timeout = timeout_r;
            wr_start   = now_r;
          end
          if (drop) begin
            count_nxt = cnt_m1;
          end
          if ((mode_r == MODE_CHECK) && expired) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_EXPIRY;
            out_exp_nxt    = 1'b1;
            out_key_nxt    = OUT_KEY_W'(head_key[CW-1:0]);
            out_last_nxt   = 1'b0;
            out_cnt_nxt    = OUT_CNT_W'(cnt_m1);
          end
        end else begin
          state_nxt     = S_IDLE;
          busy_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = OUT_CNT_W'(count_r);
          case (mode_r)
            MODE_ADD: begin
              if (found_r) begin
                out_status_nxt = STAT_REARMED;
              end else begin
                ctl.wr_en      = 1'b1;
                wr_idx         = IDX_W'(count_r);
                wr_key         = key_r;
                wr_timeout     = timeout_r;
                wr_start       = now_r;
                count_nxt      = count_r + 1'b1;
                out_cnt_nxt    = OUT_CNT_W'(count_r + 1'b1);
                out_status_nxt = STAT_ADDED;
              end
            end
            MODE_REMOVE: begin
              out_status_nxt = found_r ? STAT_REMOVED : STAT_NOTFOUND;
            end
            default: begin
              out_status_nxt = STAT_EXPIRY;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      count_r     <= '0;
      rem_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    timeout_r    <= timeout_nxt;
    now_r        <= now_nxt;
    out_status_r <= out_status_nxt;
    out_exp_r    <= out_exp_nxt;
    out_key_r    <= out_key_nxt;
    out_last_r   <= out_last_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign busy               = busy_r;
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_expired_valid  = out_exp_r;
  assign out_expired_key    = out_key_r;
  assign out_last           = out_last_r;
  assign out_entries_in_use = out_cnt_r;

endmodule

>>> src/keyed_oneshot_timer_table.sv
// Top level of the keyed one-shot timer table: a row of entry cells and their sequencer.
// Depends on kott_pkg, kott_cell and kott_ctrl.
//
// Usage: a command word (in_mode, in_key, in_timeout_ms, in_now_ms) is taken at a
// rising edge where start is high and busy is low. Results come back on the out_
// ports, each shown for exactly one cycle with out_valid high; out_last marks the
// final result of a command. The receiver cannot stall the block.
// Cancel and an add on a full table do not rotate the table: the result is shown in the
// cycle after the command, and busy stays low.
// Add, remove and check rotate the table once through the head cell, one entry per
// cycle, so busy stays high while the N entries in use (at most TABLE_DEPTH) pass the
// head cell and for the closing step after them. The next command can be given in the
// first cycle with busy low. A check shows each expired key in the cycle after its entry
// sits in the head cell, in table order, and the closing result in the first cycle with
// busy low; the other commands show their single result in that same cycle.
// Reset clears the entry count and the control state; the entry cells need no
// clearing, since only entries below the count are ever read.
module keyed_oneshot_timer_table
  import kott_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = DEF_KEY_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_mode,
  input  logic [15:0]          in_key,
  input  logic [TIME_W-1:0]    in_timeout_ms,
  input  logic [TIME_W-1:0]    in_now_ms,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic                 out_expired_valid,
  output logic [OUT_KEY_W-1:0] out_expired_key,
  output logic                 out_last,
  output logic [OUT_CNT_W-1:0] out_entries_in_use
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  kott_ctl_t           ctl;
  logic [IDX_W-1:0]    wr_idx;
  logic [KEY_BITS-1:0] wr_key;
  logic [TIME_W-1:0]   wr_timeout;
  logic [TIME_W-1:0]   wr_start;

  logic [KEY_BITS-1:0] cell_key     [TABLE_DEPTH];
  logic [TIME_W-1:0]   cell_timeout [TABLE_DEPTH];
  logic [TIME_W-1:0]   cell_start   [TABLE_DEPTH];

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0] nbr_key;
    logic [TIME_W-1:0]   nbr_timeout;
    logic [TIME_W-1:0]   nbr_start;

    if (i < TABLE_DEPTH - 1) begin : g_link
      assign nbr_key     = cell_key[i+1];
      assign nbr_timeout = cell_timeout[i+1];
      assign nbr_start   = cell_start[i+1];
    end else begin : g_end
      assign nbr_key     = '0;
      assign nbr_timeout = '0;
      assign nbr_start   = '0;
    end

    kott_cell #(
      .KEY_BITS (KEY_BITS),
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .wr_idx      (wr_idx),
      .wr_key      (wr_key),
      .wr_timeout  (wr_timeout),
      .wr_start    (wr_start),
      .nbr_key     (nbr_key),
      .nbr_timeout (nbr_timeout),
      .nbr_start   (nbr_start),
      .key         (cell_key[i]),
      .timeout     (cell_timeout[i]),
      .start_time  (cell_start[i])
    );
  end

  kott_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .CNT_W       (CNT_W),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_key             (in_key),
    .in_timeout_ms      (in_timeout_ms),
    .in_now_ms          (in_now_ms),
    .head_key           (cell_key[0]),
    .head_timeout       (cell_timeout[0]),
    .head_start         (cell_start[0]),
    .ctl                (ctl),
    .wr_idx             (wr_idx),
    .wr_key             (wr_key),
    .wr_timeout         (wr_timeout),
    .wr_start           (wr_start),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_expired_valid  (out_expired_valid),
    .out_expired_key    (out_expired_key),
    .out_last           (out_last),
    .out_entries_in_use (out_entries_in_use)
  );

endmodule

>>> src/kott_checker.sv
// Port-level checks for the keyed one-shot timer table, bound to the top level.
// Depends on kott_pkg and keyed_oneshot_timer_table.
module kott_checker
  import kott_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic [1:0]           in_mode,
  input logic                 out_valid,
  input logic [2:0]           out_status,
  input logic                 out_expired_valid,
  input logic [OUT_KEY_W-1:0] out_expired_key,
  input logic                 out_last,
  input logic [OUT_CNT_W-1:0] out_entries_in_use
);

  a_expiry_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_expired_valid |-> !out_last && (out_status == STAT_EXPIRY))
    else $error("expired key word is not a non-final expiry word");

  a_expiry_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_expired_valid |-> busy)
    else $error("expired key shown after the command has ended");

  a_other_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_expired_valid |-> out_last && (out_expired_key == '0))
    else $error("result without an expired key is not a clean final word");

  a_cancel: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_mode == MODE_CANCEL) |=>
      out_valid && out_last && (out_status == STAT_CLEARED) && (out_entries_in_use == '0))
    else $error("cancel did not answer with an empty table");

  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid && out_last)
    else $error("busy fell without the final result word");

endmodule

bind keyed_oneshot_timer_table kott_checker u_kott_checker (.*);
